FILE: sv/ffca_pkg.sv
// Shared types, status codes and default sizes for the first-fit chunk allocator.
package ffca_pkg;

    localparam int unsigned POOL_BYTES_DEF   = 1048576;
    localparam int unsigned HEADER_BYTES_DEF = 16;
    localparam int unsigned ALIGN_BYTES_DEF  = 8;
    localparam int unsigned MAX_CHUNKS_DEF   = 64;

    localparam int unsigned OFFSET_W = 20;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FREE_W   = 21;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL_OR_FREE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN      = 3'd4;

    // Command broadcast along the row of cells
    typedef enum logic [3:0] {
        OP_HOLD   = 4'b0001,
        OP_WRITE  = 4'b0010,
        OP_INSERT = 4'b0100,
        OP_REMOVE = 4'b1000
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     at;    // this cell is the target position
        logic     past;  // this cell lies above the target position
    } cell_ctl_t;

endpackage

FILE: sv/first_fit_chunk_allocator_top.sv
// Time to out_valid grows with the number of entries scanned.
// One item at a time; the scan reads one entry per cycle, and inserts and
// removes shift every cell of the row together.
// Reset (rst_n, async, low) leaves one free chunk spanning the pool; no clearing pass.
// Top level of the first-fit chunk allocator.
module first_fit_chunk_allocator_top #(
    parameter int unsigned POOL_BYTES   = ffca_pkg::POOL_BYTES_DEF,
    parameter int unsigned HEADER_BYTES = ffca_pkg::HEADER_BYTES_DEF,
    parameter int unsigned ALIGN_BYTES  = ffca_pkg::ALIGN_BYTES_DEF,
    parameter int unsigned MAX_CHUNKS   = ffca_pkg::MAX_CHUNKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [31:0]                       request_bytes,
    input  logic [ffca_pkg::OFFSET_W-1:0]     payload_offset,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ffca_pkg::OFFSET_W-1:0]     granted_offset,
    output logic [ffca_pkg::STATUS_W-1:0]     status,
    output logic [ffca_pkg::FREE_W-1:0]       free_bytes
);

    localparam int unsigned OW   = $clog2(POOL_BYTES + 1);
    localparam int unsigned NW   = $clog2(POOL_BYTES + 256);
    localparam int unsigned CIW  = $clog2(MAX_CHUNKS);
    localparam int unsigned CNTW = $clog2(MAX_CHUNKS + 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_PREP    = 11'b00000000010,
        S_CHECK   = 11'b00000000100,
        S_SCAN    = 11'b00000001000,
        S_A_WR    = 11'b00000010000,
        S_A_INS   = 11'b00000100000,
        S_F_WR    = 11'b00001000000,
        S_F_NXT   = 11'b00010000000,
        S_F_NXTRM = 11'b00100000000,
        S_F_PRV   = 11'b01000000000,
        S_F_PRVRM = 11'b10000000000
    } state_t;

    // S_DONE folded into a flag so the one-hot set stays small
    state_t                        state_reg, state_next;
    logic                          done_reg, done_next;
    logic                          mode_reg, mode_next;
    logic [31:0]                   req_reg, req_next;
    logic [ffca_pkg::OFFSET_W-1:0] off_reg, off_next;
    logic [NW-1:0]                 aligned_reg, aligned_next;
    logic [NW-1:0]                 need_reg, need_next;
    logic                          big_reg, big_next;
    logic [CNTW-1:0]               idx_reg, idx_next;
    logic [CNTW-1:0]               count_reg, count_next;
    logic [OW-1:0]                 free_reg, free_next;
    logic [OW-1:0]                 sav_base_reg, sav_base_next;
    logic [OW-1:0]                 sav_pay_reg, sav_pay_next;
    logic [ffca_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [OW-1:0]                 grant_reg, grant_next;

    logic                          out_valid_reg, out_valid_next;
    logic [ffca_pkg::OFFSET_W-1:0] out_grant_reg, out_grant_next;
    logic [ffca_pkg::STATUS_W-1:0] out_st_reg, out_st_next;
    logic [ffca_pkg::FREE_W-1:0]   out_free_reg, out_free_next;

    logic [OW-1:0]  cell_base [MAX_CHUNKS];
    logic [OW-1:0]  cell_pay  [MAX_CHUNKS];
    logic           cell_use  [MAX_CHUNKS];

    ffca_pkg::cell_op_t cmd_op;
    logic [CIW-1:0]     cmd_pos;
    logic [OW-1:0]      wr_base, wr_pay;
    logic               wr_use;

    logic [CIW-1:0]     rd_idx;
    logic [OW-1:0]      rd_base, rd_pay;
    logic               rd_use;
    logic [32:0]        rounded;

    assign rd_base = cell_base[rd_idx];
    assign rd_pay  = cell_pay[rd_idx];
    assign rd_use  = cell_use[rd_idx];

    assign rounded = (({1'b0, req_reg} + 33'(ALIGN_BYTES - 1)) / ALIGN_BYTES) * ALIGN_BYTES;

    assign in_ready = (state_reg == S_IDLE) && !done_reg;

    always_comb
    begin
        state_next     = state_reg;
        done_next      = done_reg;
        mode_next      = mode_reg;
        req_next       = req_reg;
        off_next       = off_reg;
        aligned_next   = aligned_reg;
        need_next      = need_reg;
        big_next       = big_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        free_next      = free_reg;
        sav_base_next  = sav_base_reg;
        sav_pay_next   = sav_pay_reg;
        st_next        = st_reg;
        grant_next     = grant_reg;
        out_valid_next = out_valid_reg;
        out_grant_next = out_grant_reg;
        out_st_next    = out_st_reg;
        out_free_next  = out_free_reg;
        cmd_op         = ffca_pkg::OP_HOLD;
        cmd_pos        = '0;
        wr_base        = sav_base_reg;
        wr_pay         = sav_pay_reg;
        wr_use         = 1'b0;
        rd_idx         = idx_reg[CIW-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (done_reg)
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_valid_next = 1'b1;
                out_grant_next = ffca_pkg::OFFSET_W'(grant_reg);
                out_st_next    = st_reg;
                out_free_next  = ffca_pkg::FREE_W'(free_reg);
                done_next      = 1'b0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_next  = mode;
                        req_next   = request_bytes;
                        off_next   = payload_offset;
                        grant_next = '0;
                        st_next    = ffca_pkg::ST_OK;
                        idx_next   = '0;
                        state_next = S_PREP;
                    end
                end
                S_PREP:
                begin
                    big_next     = {1'b0, req_reg} > 33'(POOL_BYTES);
                    aligned_next = NW'(rounded);
                    need_next    = NW'(rounded) + NW'(HEADER_BYTES);
                    if (mode_reg && off_reg == '0)
                    begin
                        st_next    = ffca_pkg::ST_NULL_OR_FREE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = mode_reg ? S_SCAN : S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (big_reg || need_reg > NW'(free_reg))
                    begin
                        st_next    = ffca_pkg::ST_NO_SPACE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    sav_base_next = rd_base;
                    sav_pay_next  = rd_pay;
                    if (idx_reg >= count_reg)
                    begin
                        st_next    = mode_reg ? ffca_pkg::ST_UNKNOWN : ffca_pkg::ST_NO_SPACE;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (!mode_reg)
                    begin
                        if (!rd_use && NW'(rd_pay) >= need_reg)
                        begin
                            if (count_reg >= CNTW'(MAX_CHUNKS))
                            begin
                                st_next    = ffca_pkg::ST_TABLE_FULL;
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_A_WR;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (NW'(rd_base) + NW'(HEADER_BYTES) == NW'(off_reg))
                        begin
                            if (!rd_use)
                            begin
                                st_next    = ffca_pkg::ST_NULL_OR_FREE;
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_F_WR;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
                S_A_WR:
                begin
                    cmd_op     = ffca_pkg::OP_WRITE;
                    cmd_pos    = idx_reg[CIW-1:0];
                    wr_pay     = OW'(aligned_reg);
                    wr_use     = 1'b1;
                    state_next = S_A_INS;
                end
                S_A_INS:
                begin
                    cmd_op     = ffca_pkg::OP_INSERT;
                    cmd_pos    = CIW'(idx_reg + 1'b1);
                    wr_base    = OW'(NW'(sav_base_reg) + need_reg);
                    wr_pay     = OW'(NW'(sav_pay_reg) - need_reg);
                    wr_use     = 1'b0;
                    count_next = count_reg + 1'b1;
                    free_next  = OW'(NW'(free_reg) - need_reg);
                    grant_next = OW'(NW'(sav_base_reg) + NW'(HEADER_BYTES));
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                S_F_WR:
                begin
                    cmd_op     = ffca_pkg::OP_WRITE;
                    cmd_pos    = idx_reg[CIW-1:0];
                    wr_use     = 1'b0;
                    free_next  = free_reg + sav_pay_reg + OW'(HEADER_BYTES);
                    state_next = S_F_NXT;
                end
                S_F_NXT:
                begin
                    rd_idx = CIW'(idx_reg + 1'b1);
                    if ((idx_reg + 1'b1) < count_reg && !rd_use)
                    begin
                        // absorb the free neighbour above
                        sav_pay_next = sav_pay_reg + rd_pay + OW'(HEADER_BYTES);
                        cmd_op       = ffca_pkg::OP_WRITE;
                        cmd_pos      = idx_reg[CIW-1:0];
                        wr_pay       = sav_pay_reg + rd_pay + OW'(HEADER_BYTES);
                        wr_use       = 1'b0;
                        state_next   = S_F_NXTRM;
                    end
                    else
                    begin
                        state_next = S_F_PRV;
                    end
                end
                S_F_NXTRM:
                begin
                    cmd_op     = ffca_pkg::OP_REMOVE;
                    cmd_pos    = CIW'(idx_reg + 1'b1);
                    count_next = count_reg - 1'b1;
                    state_next = S_F_PRV;
                end
                S_F_PRV:
                begin
                    rd_idx = CIW'(idx_reg - 1'b1);
                    if (idx_reg != '0 && !rd_use)
                    begin
                        cmd_op     = ffca_pkg::OP_WRITE;
                        cmd_pos    = CIW'(idx_reg - 1'b1);
                        wr_base    = rd_base;
                        wr_pay     = rd_pay + sav_pay_reg + OW'(HEADER_BYTES);
                        wr_use     = 1'b0;
                        state_next = S_F_PRVRM;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                S_F_PRVRM:
                begin
                    cmd_op     = ffca_pkg::OP_REMOVE;
                    cmd_pos    = idx_reg[CIW-1:0];
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            count_reg     <= CNTW'(1);
            free_reg      <= OW'(POOL_BYTES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        req_reg      <= req_next;
        off_reg      <= off_next;
        aligned_reg  <= aligned_next;
        need_reg     <= need_next;
        big_reg      <= big_next;
        idx_reg      <= idx_next;
        sav_base_reg <= sav_base_next;
        sav_pay_reg  <= sav_pay_next;
        st_reg       <= st_next;
        grant_reg    <= grant_next;
        out_grant_reg <= out_grant_next;
        out_st_reg   <= out_st_next;
        out_free_reg <= out_free_next;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_CHUNKS; g++)
        begin : g_cell
            ffca_pkg::cell_ctl_t ctl;
            logic [OW-1:0]       lo_base, lo_pay, hi_base, hi_pay;
            logic                lo_use, hi_use;

            assign ctl.op   = cmd_op;
            assign ctl.at   = (CIW'(g) == cmd_pos);
            assign ctl.past = (CIW'(g) > cmd_pos);

            if (g == 0)
            begin : g_lo_edge
                assign lo_base = '0;
                assign lo_pay  = '0;
                assign lo_use  = 1'b0;
            end
            else
            begin : g_lo
                assign lo_base = cell_base[g-1];
                assign lo_pay  = cell_pay[g-1];
                assign lo_use  = cell_use[g-1];
            end

            if (g == MAX_CHUNKS - 1)
            begin : g_hi_edge
                assign hi_base = '0;
                assign hi_pay  = '0;
                assign hi_use  = 1'b0;
            end
            else
            begin : g_hi
                assign hi_base = cell_base[g+1];
                assign hi_pay  = cell_pay[g+1];
                assign hi_use  = cell_use[g+1];
            end

            ffca_cell #(
                .OW       (OW),
                .RST_BASE (0),
                .RST_PAY  ((g == 0) ? (POOL_BYTES - HEADER_BYTES) : 0)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .wr_base  (wr_base),
                .wr_pay   (wr_pay),
                .wr_use   (wr_use),
                .lo_base  (lo_base),
                .lo_pay   (lo_pay),
                .lo_use   (lo_use),
                .hi_base  (hi_base),
                .hi_pay   (hi_pay),
                .hi_use   (hi_use),
                .base     (cell_base[g]),
                .pay      (cell_pay[g]),
                .use_flag (cell_use[g])
            );
        end
    endgenerate

    assign out_valid      = out_valid_reg;
    assign granted_offset = out_grant_reg;
    assign status         = out_st_reg;
    assign free_bytes     = out_free_reg;

endmodule

FILE: sv/ffca_cell.sv
// One table entry of the chunk row: base, payload size and in-use flag.
module ffca_cell #(
    parameter int unsigned OW        = 21,
    parameter int unsigned RST_BASE  = 0,
    parameter int unsigned RST_PAY   = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ffca_pkg::cell_ctl_t ctl,
    input  logic [OW-1:0]       wr_base,
    input  logic [OW-1:0]       wr_pay,
    input  logic                wr_use,
    input  logic [OW-1:0]       lo_base,
    input  logic [OW-1:0]       lo_pay,
    input  logic                lo_use,
    input  logic [OW-1:0]       hi_base,
    input  logic [OW-1:0]       hi_pay,
    input  logic                hi_use,
    output logic [OW-1:0]       base,
    output logic [OW-1:0]       pay,
    output logic                use_flag
);

    logic [OW-1:0] base_reg, base_next;
    logic [OW-1:0] pay_reg,  pay_next;
    logic          use_reg,  use_next;

    always_comb
    begin
        base_next = base_reg;
        pay_next  = pay_reg;
        use_next  = use_reg;
        unique case (ctl.op)
            ffca_pkg::OP_HOLD:
            begin
            end
            ffca_pkg::OP_WRITE:
            begin
                if (ctl.at)
                begin
                    base_next = wr_base;
                    pay_next  = wr_pay;
                    use_next  = wr_use;
                end
            end
            ffca_pkg::OP_INSERT:
            begin
                if (ctl.at)
                begin
                    base_next = wr_base;
                    pay_next  = wr_pay;
                    use_next  = wr_use;
                end
                else if (ctl.past)
                begin
                    base_next = lo_base;
                    pay_next  = lo_pay;
                    use_next  = lo_use;
                end
            end
            ffca_pkg::OP_REMOVE:
            begin
                if (ctl.at || ctl.past)
                begin
                    base_next = hi_base;
                    pay_next  = hi_pay;
                    use_next  = hi_use;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= OW'(RST_BASE);
            pay_reg  <= OW'(RST_PAY);
            use_reg  <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            pay_reg  <= pay_next;
            use_reg  <= use_next;
        end
    end

    assign base     = base_reg;
    assign pay      = pay_reg;
    assign use_flag = use_reg;

endmodule

FILE: sv/ffca_checker.sv
// Port-level checks for the chunk allocator, bound to the top level.
module ffca_checker #(
    parameter int unsigned POOL_BYTES = ffca_pkg::POOL_BYTES_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ffca_pkg::OFFSET_W-1:0]     granted_offset,
    input logic [ffca_pkg::STATUS_W-1:0]     status,
    input logic [ffca_pkg::FREE_W-1:0]       free_bytes
);

    // a failed or free beat never carries an offset
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ffca_pkg::ST_OK) |-> (granted_offset == '0))
        else $error("offset on a failed beat");

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ffca_pkg::FREE_W'(free_bytes) <= ffca_pkg::FREE_W'(POOL_BYTES)))
        else $error("free count beyond pool");

    // one item in flight: nothing accepted while a result is being formed
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(free_bytes)))
        else $error("result beat dropped under stall");

endmodule

bind first_fit_chunk_allocator_top ffca_checker #(
    .POOL_BYTES (POOL_BYTES)
) u_ffca_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted_offset (granted_offset),
    .status         (status),
    .free_bytes     (free_bytes)
);
